>>> rtl/aple_pkg.sv
package aple_pkg;

  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned AnswerWidth   = 32;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    SCAN_START   = 2'd0,
    SCAN_NUMBER  = 2'd1,
    SCAN_KEYWORD = 2'd2,
    SCAN_SKIP    = 2'd3
  } scan_mode_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_REM  = 3'd4,
    OP_DIV  = 3'd5
  } op_code_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MALFORM = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EV_IDLE = 2'd0,
    EV_MUL  = 2'd1,
    EV_DIV  = 2'd2,
    EV_OUT  = 2'd3
  } eval_state_e;

  localparam logic signed [AnswerWidth-1:0] ErrAnswer = -32'sd10000;

  // keyword letter at position p, uppercase ASCII; zero past the end
  function automatic logic [7:0] kw_letter(input logic [1:0] k, input logic [3:0] p);
    logic [71:0] w;
    logic [3:0]  n;
    logic [7:0]  l;
    unique case (k)
      2'd0: begin w = 72'("ADD"); n = 4'd3; end
      2'd1: begin w = 72'("SUBSTRACT"); n = 4'd9; end
      2'd2: begin w = 72'("DIVIDE"); n = 4'd6; end
      default: begin w = 72'("MULTIPLE"); n = 4'd8; end
    endcase
    l = 8'h00;
    if (p < n) l = w[8*(n-p-4'd1) +: 8];
    return l;
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] n;
    unique case (k)
      2'd0: n = 4'd3;
      2'd1: n = 4'd9;
      2'd2: n = 4'd6;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic op_code_e kw_op(input logic [1:0] k);
    op_code_e o;
    unique case (k)
      2'd0: o = OP_ADD;
      2'd1: o = OP_SUB;
      2'd2: o = OP_DIV;
      default: o = OP_MUL;
    endcase
    return o;
  endfunction

  // statement handed from lexer to evaluator
  typedef struct packed {
    logic       ok_form;
    op_code_e   op;
  } stmt_hdr_t;

endpackage

>>> rtl/aple_lexer.sv
module aple_lexer #(
  parameter int unsigned ValueWidth = aple_pkg::DefValueWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  input  logic                  final_char_i,
  output logic                  st_valid_o,
  input  logic                  st_stall_i,
  output aple_pkg::stmt_hdr_t   st_hdr_o,
  output logic [ValueWidth-1:0] st_a_o,
  output logic [ValueWidth-1:0] st_b_o
);

  localparam logic [ValueWidth-1:0] ValMax = {1'b0, {(ValueWidth-1){1'b1}}};

  aple_pkg::scan_mode_e  mode_q, mode_d;
  logic [1:0]            ksel_q, ksel_d;
  logic [3:0]            kpos_q, kpos_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [2:0]            isop_q, isop_d;
  logic [ValueWidth-1:0] tv_q [3];
  logic [ValueWidth-1:0] tv_d [3];

  logic                  acc_ok;
  logic [ValueWidth+3:0] acc_x10;
  logic                  take;

  assign in_stall_o = st_valid_o & st_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  always_comb begin
    logic [7:0] c, u;
    logic [3:0] d;
    logic       start;
    logic       push_op, push_num;
    logic [ValueWidth-1:0] pv;
    mode_d = mode_q; ksel_d = ksel_q; kpos_d = kpos_q; acc_d = acc_q;
    cnt_d = cnt_q; isop_d = isop_q;
    for (int i = 0; i < 3; i++) tv_d[i] = tv_q[i];
    c = char_code_i;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    d = c[3:0];
    start = 1'b0; push_op = 1'b0; push_num = 1'b0; pv = '0;
    acc_x10 = {4'd0, acc_q} * (ValueWidth+4)'(10) + (ValueWidth+4)'(d);
    acc_ok  = acc_x10 <= {4'd0, ValMax};

    unique case (mode_q)
      aple_pkg::SCAN_NUMBER: begin
        if (c >= "0" && c <= "9") begin
          acc_d = acc_ok ? acc_x10[ValueWidth-1:0] : ValMax;
        end else begin
          push_num = 1'b1;
          start = 1'b1;
        end
      end
      aple_pkg::SCAN_KEYWORD: begin
        if (kpos_q < aple_pkg::kw_len(ksel_q) && u == aple_pkg::kw_letter(ksel_q, kpos_q)) begin
          kpos_d = kpos_q + 4'd1;
          if (kpos_d >= aple_pkg::kw_len(ksel_q)) begin
            push_op = 1'b1;
            pv = ValueWidth'(aple_pkg::kw_op(ksel_q));
            mode_d = aple_pkg::SCAN_START;
          end
        end else if (is_alpha(c)) begin
          mode_d = aple_pkg::SCAN_SKIP;
        end else begin
          start = 1'b1;
        end
      end
      aple_pkg::SCAN_SKIP: start = !is_alpha(c);
      default: start = 1'b1;
    endcase

    // a number token is pushed before the new start token
    if (push_num && cnt_d < 2'd3) begin
      isop_d[cnt_d] = 1'b0; tv_d[cnt_d] = acc_q; cnt_d = cnt_d + 2'd1;
    end
    if (start) begin
      mode_d = aple_pkg::SCAN_START;
      priority if (c == "+" || c == "-" || c == "x" || c == "%" || c == "/") begin
        push_op = 1'b1;
        pv = ValueWidth'(c == "+" ? aple_pkg::OP_ADD : c == "-" ? aple_pkg::OP_SUB :
             c == "x" ? aple_pkg::OP_MUL : c == "%" ? aple_pkg::OP_REM : aple_pkg::OP_DIV);
      end else if (u == "A" || u == "S" || u == "D" || u == "M") begin
        ksel_d = (u == "A") ? 2'd0 : (u == "S") ? 2'd1 : (u == "D") ? 2'd2 : 2'd3;
        kpos_d = 4'd1;
        mode_d = aple_pkg::SCAN_KEYWORD;
      end else if (c >= "0" && c <= "9") begin
        acc_d = ValueWidth'(d);
        mode_d = aple_pkg::SCAN_NUMBER;
      end else if (is_alpha(c)) begin
        mode_d = aple_pkg::SCAN_SKIP;
      end else begin
        // white space and other bytes leave the scanner at token start
        mode_d = aple_pkg::SCAN_START;
      end
    end
    if (push_op && cnt_d < 2'd3) begin
      isop_d[cnt_d] = 1'b1; tv_d[cnt_d] = pv; cnt_d = cnt_d + 2'd1;
    end
    if (final_char_i && mode_d == aple_pkg::SCAN_NUMBER && cnt_d < 2'd3) begin
      isop_d[cnt_d] = 1'b0; tv_d[cnt_d] = acc_d; cnt_d = cnt_d + 2'd1;
    end
  end

  // statement record built from the next-state tokens
  aple_pkg::stmt_hdr_t hdr;
  logic [ValueWidth-1:0] a_v, b_v, op_v;
  always_comb begin
    hdr.ok_form = 1'b0;
    a_v = tv_d[1]; b_v = tv_d[2]; op_v = tv_d[0];
    if (cnt_d == 2'd3 && isop_d == 3'b010) begin
      hdr.ok_form = 1'b1; a_v = tv_d[0]; op_v = tv_d[1]; b_v = tv_d[2];
    end else if (cnt_d == 2'd3 && isop_d == 3'b001) begin
      hdr.ok_form = 1'b1;
    end
    hdr.op = (op_v >= ValueWidth'(aple_pkg::OP_ADD) && op_v <= ValueWidth'(aple_pkg::OP_DIV))
           ? aple_pkg::op_code_e'(op_v[2:0]) : aple_pkg::OP_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= aple_pkg::SCAN_START; ksel_q <= '0; kpos_q <= '0; acc_q <= '0;
      cnt_q <= '0; isop_q <= '0; st_valid_o <= 1'b0;
      for (int i = 0; i < 3; i++) tv_q[i] <= '0;
    end else begin
      if (take && final_char_i) begin
        st_valid_o <= 1'b1;
      end else if (!st_stall_i) begin
        st_valid_o <= 1'b0;
      end
      if (take) begin
        if (final_char_i) begin
          mode_q <= aple_pkg::SCAN_START; ksel_q <= '0; kpos_q <= '0; acc_q <= '0;
          cnt_q <= '0; isop_q <= '0;
          for (int i = 0; i < 3; i++) tv_q[i] <= '0;
        end else begin
          mode_q <= mode_d; ksel_q <= ksel_d; kpos_q <= kpos_d; acc_q <= acc_d;
          cnt_q <= cnt_d; isop_q <= isop_d;
          for (int i = 0; i < 3; i++) tv_q[i] <= tv_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && final_char_i) begin
      st_hdr_o <= hdr; st_a_o <= a_v; st_b_o <= b_v;
    end
  end

`ifndef SYNTH
  a_kw_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == aple_pkg::SCAN_KEYWORD) |->
      (kpos_q != 4'd0 && kpos_q < aple_pkg::kw_len(ksel_q)))
    else $error("keyword position out of range");
  a_final_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && final_char_i) |=> (cnt_q == 2'd0 && mode_q == aple_pkg::SCAN_START))
    else $error("scan state not cleared after statement");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_o && st_stall_i) |=> (st_valid_o && $stable(st_a_o) && $stable(st_b_o)))
    else $error("statement record changed while stalled");
`endif

endmodule

>>> rtl/aple_queue.sv
module aple_queue #(
  parameter int unsigned ValueWidth = aple_pkg::DefValueWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_stall_o,
  input  aple_pkg::stmt_hdr_t   wr_hdr_i,
  input  logic [ValueWidth-1:0] wr_a_i,
  input  logic [ValueWidth-1:0] wr_b_i,
  output logic                  rd_valid_o,
  input  logic                  rd_stall_i,
  output aple_pkg::stmt_hdr_t   rd_hdr_o,
  output logic [ValueWidth-1:0] rd_a_o,
  output logic [ValueWidth-1:0] rd_b_o
);

  localparam int unsigned Depth = aple_pkg::QueueDepth;
  localparam int unsigned Aw    = $clog2(Depth);
  localparam int unsigned EntW  = $bits(aple_pkg::stmt_hdr_t) + 2 * ValueWidth;

  logic [EntW-1:0] mem_q [Depth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     fill_q;
  logic            wr, rd;

  assign wr_stall_o = (fill_q == (Aw+1)'(Depth));
  assign rd_valid_o = (fill_q != '0);
  assign wr = wr_valid_i & ~wr_stall_o;
  assign rd = rd_valid_o & ~rd_stall_i;
  assign {rd_hdr_o, rd_a_o, rd_b_o} = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= {wr_hdr_i, wr_a_i, wr_b_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; fill_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      fill_q <= fill_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

`ifndef SYNTH
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (Aw+1)'(Depth)) else $error("queue overfill");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> fill_q == $past(fill_q) + 1'b1) else $error("queue count slip");
  a_count_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && !wr) |=> fill_q == $past(fill_q) - 1'b1) else $error("queue count slip");
`endif

endmodule

>>> rtl/aple_eval.sv
module aple_eval #(
  parameter int unsigned ValueWidth = aple_pkg::DefValueWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  st_valid_i,
  output logic                  st_stall_o,
  input  aple_pkg::stmt_hdr_t   st_hdr_i,
  input  logic [ValueWidth-1:0] st_a_i,
  input  logic [ValueWidth-1:0] st_b_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [aple_pkg::AnswerWidth-1:0] answer_o,
  output logic [aple_pkg::StatusWidth-1:0]       status_o
);

  localparam int unsigned Cw = $clog2(ValueWidth + 1);
  localparam int unsigned Aw = aple_pkg::AnswerWidth;
  localparam int unsigned Hw = ValueWidth / 2;
  localparam int unsigned Lw = ValueWidth - Hw;

  aple_pkg::eval_state_e state_q, state_d;
  aple_pkg::op_code_e    op_q;
  logic [ValueWidth-1:0] a_q, b_q, res_q, rem_q, quo_q;
  logic [Cw-1:0]         cnt_q;
  logic [2*ValueWidth-1:0] p_lo_q, p_hi_q;
  logic                  ph_q;
  logic                  take, done_fire;
  logic [ValueWidth:0]   trial;
  logic [ValueWidth-1:0] rem_sh;
  logic                  out_free;

  assign out_free  = ~out_valid_o | ~out_stall_i;
  assign st_stall_o = (state_q != aple_pkg::EV_IDLE);
  assign take      = st_valid_i & ~st_stall_o;
  assign done_fire = (state_q == aple_pkg::EV_OUT) & out_free;

  assign rem_sh = {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, b_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aple_pkg::EV_IDLE: begin
        if (take && st_hdr_i.ok_form && st_hdr_i.op == aple_pkg::OP_MUL) begin
          state_d = aple_pkg::EV_MUL;
        end else if (take && st_hdr_i.ok_form && st_b_i != '0 &&
                     (st_hdr_i.op == aple_pkg::OP_DIV || st_hdr_i.op == aple_pkg::OP_REM)) begin
          state_d = aple_pkg::EV_DIV;
        end else if (take) begin
          state_d = aple_pkg::EV_OUT;
        end
      end
      aple_pkg::EV_MUL: if (ph_q) state_d = aple_pkg::EV_OUT;
      aple_pkg::EV_DIV: if (cnt_q == Cw'(1)) state_d = aple_pkg::EV_OUT;
      default: if (out_free) state_d = aple_pkg::EV_IDLE;
    endcase
  end

  logic [Aw-1:0] ans_v;
  logic [1:0]    sts_v;
  always_comb begin
    logic [ValueWidth-1:0] r;
    r = res_q;
    unique case (op_q)
      aple_pkg::OP_MUL: r = p_lo_q[ValueWidth-1:0] + {p_hi_q[ValueWidth-1-Lw:0], {Lw{1'b0}}};
      aple_pkg::OP_DIV: r = quo_q;
      aple_pkg::OP_REM: r = rem_q;
      default: r = res_q;
    endcase
    // res_q holds the status code only for rejected statements
    sts_v = (op_q == aple_pkg::OP_NONE) ? res_q[1:0] : 2'(aple_pkg::ST_OK);
    if (sts_v != 2'(aple_pkg::ST_OK)) ans_v = aple_pkg::ErrAnswer;
    else ans_v = Aw'($signed(r));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aple_pkg::EV_IDLE; out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_fire) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      answer_o <= ans_v; status_o <= sts_v;
    end
    unique case (state_q)
      aple_pkg::EV_IDLE: if (take) begin
        a_q <= st_a_i; b_q <= st_b_i; op_q <= st_hdr_i.op;
        cnt_q <= Cw'(ValueWidth); ph_q <= 1'b0;
        rem_q <= '0; quo_q <= st_a_i;
        if (!st_hdr_i.ok_form || st_hdr_i.op == aple_pkg::OP_NONE) begin
          op_q <= aple_pkg::OP_NONE; res_q <= ValueWidth'(aple_pkg::ST_MALFORM);
        end else if ((st_hdr_i.op == aple_pkg::OP_DIV || st_hdr_i.op == aple_pkg::OP_REM)
                     && st_b_i == '0) begin
          op_q <= aple_pkg::OP_NONE; res_q <= ValueWidth'(aple_pkg::ST_DIVZERO);
        end else if (st_hdr_i.op == aple_pkg::OP_ADD) begin
          res_q <= st_a_i + st_b_i;
        end else if (st_hdr_i.op == aple_pkg::OP_SUB) begin
          res_q <= st_a_i - st_b_i;
        end else begin
          res_q <= '0;
        end
      end
      aple_pkg::EV_MUL: begin
        // two half-width partial products, low half of b first, then high half
        if (!ph_q) p_lo_q <= (2*ValueWidth)'(a_q) * (2*ValueWidth)'(b_q[Lw-1:0]);
        else p_hi_q <= (2*ValueWidth)'(a_q) * (2*ValueWidth)'(b_q[ValueWidth-1:Lw]);
        ph_q <= 1'b1;
      end
      aple_pkg::EV_DIV: begin
        // restoring division, one quotient bit a cycle
        cnt_q <= cnt_q - Cw'(1);
        if (!trial[ValueWidth]) begin
          rem_q <= trial[ValueWidth-1:0];
          quo_q <= {quo_q[ValueWidth-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[ValueWidth-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (state_q != aple_pkg::EV_IDLE && op_q != aple_pkg::OP_NONE && state_d == aple_pkg::EV_OUT
        && state_q != aple_pkg::EV_OUT && (op_q == aple_pkg::OP_MUL ||
        op_q == aple_pkg::OP_DIV || op_q == aple_pkg::OP_REM)) begin
      res_q <= '0;
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(answer_o)))
    else $error("result changed while stalled");
  a_err_ans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 2'(aple_pkg::ST_OK)) |-> answer_o == aple_pkg::ErrAnswer)
    else $error("error answer wrong");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != aple_pkg::EV_IDLE) |-> st_stall_o) else $error("evaluator took while busy");
`endif

endmodule

>>> rtl/arithmetic_phrase_lexer_evaluator_core.sv
// Flow: a statement's record is registered in the lexer, held in the queue and evaluated; add,
//   subtract and errors go straight to output, multiply passes the partial-product phases.
// Throughput: one character per cycle; the evaluator takes one statement at a time and its
//   bit-serial divider sets the statement rate; a 2-entry queue hides short gaps, and
//   characters stall while a finished statement waits on a full queue.
// Reset: rst_ni is asynchronous, active low; clears scan state, tokens, queue pointers and valid flags.
module arithmetic_phrase_lexer_evaluator_core #(
  parameter int unsigned VALUE_WIDTH = aple_pkg::DefValueWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        final_char_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [31:0] answer_o,
  output logic [1:0]  status_o
);

  // lexer -> queue -> evaluator
  logic                   lx_valid, lx_stall, q_valid, q_stall;
  aple_pkg::stmt_hdr_t    lx_hdr, q_hdr;
  logic [VALUE_WIDTH-1:0] lx_a, lx_b, q_a, q_b;

  aple_lexer #(.ValueWidth(VALUE_WIDTH)) u_lexer (
    .clk_i, .rst_ni,
    .in_valid_i(valid_i), .in_stall_o(stall_o),
    .char_code_i, .final_char_i,
    .st_valid_o(lx_valid), .st_stall_i(lx_stall),
    .st_hdr_o(lx_hdr), .st_a_o(lx_a), .st_b_o(lx_b)
  );

  aple_queue #(.ValueWidth(VALUE_WIDTH)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(lx_valid), .wr_stall_o(lx_stall),
    .wr_hdr_i(lx_hdr), .wr_a_i(lx_a), .wr_b_i(lx_b),
    .rd_valid_o(q_valid), .rd_stall_i(q_stall),
    .rd_hdr_o(q_hdr), .rd_a_o(q_a), .rd_b_o(q_b)
  );

  aple_eval #(.ValueWidth(VALUE_WIDTH)) u_eval (
    .clk_i, .rst_ni,
    .st_valid_i(q_valid), .st_stall_o(q_stall),
    .st_hdr_i(q_hdr), .st_a_i(q_a), .st_b_i(q_b),
    .out_valid_o(valid_o), .out_stall_i(stall_i),
    .answer_o, .status_o
  );

endmodule

>>> tb/sv/tb_arithmetic_phrase_lexer_evaluator_core.sv
`timescale 1ns / 1ps

module tb_arithmetic_phrase_lexer_evaluator_core;

  localparam int unsigned VW = 32;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        final_char_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic signed [31:0] answer_o;
  logic [1:0]  status_o;

  arithmetic_phrase_lexer_evaluator_core #(.VALUE_WIDTH(VW)) u_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .char_code_i, .final_char_i,
    .valid_o, .stall_i, .answer_o, .status_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Expected statement results, oldest first
  typedef struct packed {
    logic signed [31:0] answer;
    aple_pkg::status_e  status;
  } stmt_result_t;

  stmt_result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 0;

  // Lexer shadow state
  aple_pkg::scan_mode_e sh_mode;
  logic [1:0]  sh_kw;
  logic [3:0]  sh_pos;
  logic [63:0] sh_acc;
  int unsigned sh_count;
  logic        sh_is_op [3];
  logic [31:0] sh_val [3];

  string    kw_words [4] = '{"ADD", "SUBSTRACT", "DIVIDE", "MULTIPLE"};
  aple_pkg::op_code_e kw_ops [4] = '{aple_pkg::OP_ADD, aple_pkg::OP_SUB,
                                     aple_pkg::OP_DIV, aple_pkg::OP_MUL};

  byte unsigned stmt[$];

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  task automatic clear_lexer();
    sh_mode = aple_pkg::SCAN_START;
    sh_kw = '0;
    sh_pos = '0;
    sh_acc = '0;
    sh_count = 0;
    for (int i = 0; i < 3; i++) begin
      sh_is_op[i] = 1'b0;
      sh_val[i] = '0;
    end
  endtask

  task automatic keep_token(logic is_op, logic [31:0] v);
    if (sh_count < 3) begin
      sh_is_op[sh_count] = is_op;
      sh_val[sh_count] = v;
      sh_count++;
    end
  endtask

  task automatic token_start(logic [7:0] c);
    logic [7:0] u;
    u = upcase(c);
    sh_mode = aple_pkg::SCAN_START;
    case (c)
      "+": begin keep_token(1'b1, 32'(aple_pkg::OP_ADD)); return; end
      "-": begin keep_token(1'b1, 32'(aple_pkg::OP_SUB)); return; end
      "x": begin keep_token(1'b1, 32'(aple_pkg::OP_MUL)); return; end
      "%": begin keep_token(1'b1, 32'(aple_pkg::OP_REM)); return; end
      "/": begin keep_token(1'b1, 32'(aple_pkg::OP_DIV)); return; end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) begin
      if (kw_words[k][0] == u) begin
        sh_kw = k[1:0];
        sh_pos = 4'd1;
        sh_mode = aple_pkg::SCAN_KEYWORD;
        return;
      end
    end
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (is_digit(c)) begin
      sh_acc = 64'(c - "0");
      sh_mode = aple_pkg::SCAN_NUMBER;
    end else if (is_alpha(c)) begin
      sh_mode = aple_pkg::SCAN_SKIP;
    end
  endtask

  // Advance the shadow lexer by one character; on the final one, queue the answer
  task automatic lex_char(logic [7:0] c, logic fin);
    logic [63:0]  d, mx, a, b, r;
    logic [31:0]  op;
    aple_pkg::status_e st;
    stmt_result_t res;
    mx = (64'd1 << (VW - 1)) - 1;
    case (sh_mode)
      aple_pkg::SCAN_NUMBER: begin
        if (is_digit(c)) begin
          d = 64'(c - "0");
          if (sh_acc > (mx - d) / 10) sh_acc = mx;
          else sh_acc = sh_acc * 10 + d;
        end else begin
          keep_token(1'b0, sh_acc[31:0]);
          token_start(c);
        end
      end
      aple_pkg::SCAN_KEYWORD: begin
        if (sh_pos < kw_words[sh_kw].len() && upcase(c) == kw_words[sh_kw][sh_pos]) begin
          sh_pos++;
          if (sh_pos >= kw_words[sh_kw].len()) begin
            keep_token(1'b1, 32'(kw_ops[sh_kw]));
            sh_mode = aple_pkg::SCAN_START;
          end
        end else if (is_alpha(c)) begin
          sh_mode = aple_pkg::SCAN_SKIP;
        end else begin
          token_start(c);
        end
      end
      aple_pkg::SCAN_SKIP: if (!is_alpha(c)) token_start(c);
      default: token_start(c);
    endcase
    if (!fin) return;

    if (sh_mode == aple_pkg::SCAN_NUMBER) keep_token(1'b0, sh_acc[31:0]);
    st = aple_pkg::ST_OK;
    r = '0;
    a = '0;
    b = '0;
    op = 32'(aple_pkg::OP_NONE);
    if (sh_count < 3) begin
      st = aple_pkg::ST_MALFORM;
    end else if (!sh_is_op[0] && sh_is_op[1] && !sh_is_op[2]) begin
      a = sh_val[0]; op = sh_val[1]; b = sh_val[2];
    end else if (sh_is_op[0] && !sh_is_op[1] && !sh_is_op[2]) begin
      op = sh_val[0]; a = sh_val[1]; b = sh_val[2];
    end else begin
      st = aple_pkg::ST_MALFORM;
    end
    if (st == aple_pkg::ST_OK) begin
      case (op)
        aple_pkg::OP_ADD: r = a + b;
        aple_pkg::OP_SUB: r = a - b;
        aple_pkg::OP_MUL: r = a * b;
        aple_pkg::OP_REM: if (b == 0) st = aple_pkg::ST_DIVZERO; else r = a % b;
        aple_pkg::OP_DIV: if (b == 0) st = aple_pkg::ST_DIVZERO; else r = a / b;
        default: st = aple_pkg::ST_MALFORM;
      endcase
    end
    res.status = st;
    res.answer = (st == aple_pkg::ST_OK) ? signed'(r[31:0]) : aple_pkg::ErrAnswer;
    pending_results.push_back(res);
    clear_lexer();
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH @%0t %s: got %0d expected %0d", $realtime, what,
             signed'(got), signed'(want));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    stmt_result_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** arithmetic_phrase_lexer_evaluator_core: FAILED **");
      $finish;
    end
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", answer_o, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report("status", 32'(status_o), 32'(want.status));
        if (answer_o !== want.answer) report("answer", answer_o, want.answer);
      end
    end
  end

  // Receiver stall: pattern shifts between none, light, heavy and long stretches
  int unsigned stall_mode = 0, stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 9) < 2);
      2: stall_i <= ($urandom_range(0, 9) < 7);
      default: stall_i <= (stall_left % 16) < 12;
    endcase
  end

  // One character transaction; entered and left at a falling edge
  task automatic send_char(logic [7:0] c, logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    valid_i <= 1'b1;
    char_code_i <= c;
    final_char_i <= fin;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    lex_char(c, fin);
    @(negedge clk_i);
  endtask

  task automatic send_stmt();
    foreach (stmt[i]) send_char(stmt[i], i == stmt.size() - 1);
    stmt.delete();
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) stmt.push_back(s[i]);
  endtask

  // Hold the sender until every queued answer has come back
  task automatic drain();
    valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Random statement pieces
  task automatic add_number();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 3);
    if ($urandom_range(0, 7) == 0) begin
      push_text("0");
      return;
    end
    repeat (n) stmt.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic add_operator();
    int unsigned k;
    string w;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 4))
        0: push_text("+");
        1: push_text("-");
        2: push_text("x");
        3: push_text("%");
        default: push_text("/");
      endcase
    end else begin
      k = $urandom_range(0, 3);
      w = kw_words[k];
      for (int i = 0; i < w.len(); i++)
        stmt.push_back($urandom_range(0, 1) ? w[i] : w[i] + 8'd32);
      // keyword glued to a following letter still counts once matched
      if ($urandom_range(0, 5) == 0) push_text("s");
    end
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 5))
      0: push_text("hello");
      1: push_text("Dix");
      2: push_text("ADx");
      3: push_text("multi+");
      4: stmt.push_back(8'($urandom_range(0, 255)));
      default: push_text("\t");
    endcase
  endtask

  task automatic add_gap();
    if ($urandom_range(0, 3) != 0) push_text(" ");
    if ($urandom_range(0, 9) == 0) add_noise();
    if ($urandom_range(0, 4) == 0) push_text(" ");
  endtask

  task automatic build_random_stmt();
    int unsigned shape;
    shape = $urandom_range(0, 9);
    if (shape < 4) begin
      add_number(); add_gap(); add_operator(); add_gap(); add_number();
    end else if (shape < 7) begin
      add_operator(); push_text(" "); add_number(); push_text(" "); add_number();
      add_gap();
    end else if (shape == 7) begin
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 1)) add_number(); else add_operator();
        add_gap();
      end
    end else begin
      repeat ($urandom_range(1, 6)) add_noise();
    end
    if (stmt.size() == 0) push_text("?");
  endtask

  task automatic test_operators();
    push_text("9-12"); send_stmt();
    push_text("x7 6"); send_stmt();
    push_text("8/3"); send_stmt();
  endtask

  task automatic test_keyword_and_remainder();
    push_text("ADD1 2"); send_stmt();
    push_text("%9 4"); send_stmt();
  endtask

  task automatic test_error_cases();
    push_text("5"); send_stmt();
    push_text("%5 0"); send_stmt();
    stmt.push_back(8'hFF); send_stmt();
  endtask

  task automatic test_random_statements(int unsigned chars_total);
    int unsigned sent;
    int unsigned pause_at;
    sent = 0;
    pause_at = chars_total / 2;
    while (sent < chars_total) begin
      build_random_stmt();
      sent += stmt.size();
      send_stmt();
      if (sent >= pause_at && pause_at != 0) begin
        drain();
        pause_at = 0;
      end
    end
  endtask

  initial begin
    clear_lexer();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_operators();
    test_keyword_and_remainder();
    test_error_cases();
    test_random_statements(1080);

    drain();
    repeat (VW + 8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** arithmetic_phrase_lexer_evaluator_core: PASSED **");
    end else begin
      $display("** arithmetic_phrase_lexer_evaluator_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/aple_pkg.sv
rtl/aple_lexer.sv
rtl/aple_queue.sv
rtl/aple_eval.sv
rtl/arithmetic_phrase_lexer_evaluator_core.sv
tb/sv/tb_arithmetic_phrase_lexer_evaluator_core.sv
